[hw/rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk, off while rst_n is low.
`define ASSERT_CLK(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check on clk, also live during reset.
`define ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/adc_dip_pkg.sv]
`default_nettype none

package adc_dip_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int FRAC_BITS   = 16;
    localparam int ACC_BITS    = SAMPLE_BITS + FRAC_BITS;
    localparam int OUT_SHIFT   = 12;
    localparam int REG_BITS    = 16;
    localparam int AVG_BITS    = 16;
    localparam int COUNT_BITS  = 16;
    localparam int CFG_IDX_BITS = 2;
    localparam int PROD_BITS   = ACC_BITS + 1 + REG_BITS + 1;

    typedef logic [SAMPLE_BITS-1:0]  sample_t;
    typedef logic [ACC_BITS-1:0]     acc_t;
    typedef logic [REG_BITS-1:0]     cfg_word_t;
    typedef logic [COUNT_BITS-1:0]   count_t;
    typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_EMA_WEIGHT   = 2'd0,
        CFG_DIP_MARGIN   = 2'd1,
        CFG_REARM_MARGIN = 2'd2
    } cfg_reg_t;

    localparam cfg_word_t EMA_WEIGHT_RST   = 16'd655;
    localparam cfg_word_t DIP_MARGIN_RST   = 16'd3640;
    localparam cfg_word_t REARM_MARGIN_RST = 16'd1092;
    localparam count_t    COUNT_MAX        = {COUNT_BITS{1'b1}};

endpackage

`default_nettype wire

[hw/rtl/adc_dip_detector.sv]
// A window_last item's result passes the p stage register, then the output register.
// Throughput: one item per cycle when not stalled; the average multiply-add sets the cycle.
// A last item held behind a result that is not yet taken stalls the input until it is taken.
// Items without window_last update state and produce no result.
// Reset (rst_n low, asynchronous): config and control registers return to their defaults,
// the average is unseeded, detection is armed and the next item opens a new window.
`default_nettype none

module adc_dip_detector (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_wr_en,
    input  wire adc_dip_pkg::cfg_idx_t     cfg_index,
    input  wire adc_dip_pkg::cfg_word_t    cfg_data,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire adc_dip_pkg::sample_t      sample,
    input  wire logic                      window_last,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output adc_dip_pkg::sample_t           window_min,
    output adc_dip_pkg::sample_t           window_max,
    output logic [adc_dip_pkg::AVG_BITS-1:0] average_level,
    output adc_dip_pkg::count_t            dip_count
);
    import adc_dip_pkg::*;

    `include "assert_macros.svh"

    cfg_word_t ema_weight_reg;
    cfg_word_t dip_margin_reg;
    cfg_word_t rearm_margin_reg;

    acc_t    acc_reg, acc_next;
    logic    unseeded_reg;
    logic    window_start_reg;
    sample_t low_mark_reg, low_mark_next;
    sample_t high_mark_reg, high_mark_next;

    logic    p_valid_reg;
    logic    p_last_reg;
    sample_t p_sample_reg;
    acc_t    p_acc_reg;
    sample_t p_min_reg;
    sample_t p_max_reg;

    logic    armed_reg, armed_next;
    count_t  dips_reg, dips_next;

    logic    out_valid_reg;
    sample_t out_min_reg;
    sample_t out_max_reg;
    logic [AVG_BITS-1:0] out_avg_reg;
    count_t  out_dips_reg;

    logic    out_free;
    logic    p_ready;
    logic    in_fire;
    logic    p_fire;

    acc_t    s_fix;
    acc_t    acc_base;
    logic signed [ACC_BITS:0]    diff;
    logic signed [REG_BITS:0]    weight_s;
    logic signed [PROD_BITS-1:0] prod;
    logic signed [PROD_BITS-1:0] prod_rnd;
    logic signed [PROD_BITS-1:0] step;

    acc_t    p_sfix;
    logic [ACC_BITS:0] dip_lhs;
    logic [ACC_BITS:0] rearm_rhs;
    logic    dip_hit;
    logic    rearm_hit;

    assign out_free = !out_valid_reg || out_ready;
    assign p_ready  = !p_valid_reg || !p_last_reg || out_free;
    assign in_ready = p_ready;
    assign in_fire  = in_valid && in_ready;
    assign p_fire   = p_valid_reg && p_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ema_weight_reg   <= EMA_WEIGHT_RST;
            dip_margin_reg   <= DIP_MARGIN_RST;
            rearm_margin_reg <= REARM_MARGIN_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_EMA_WEIGHT:   ema_weight_reg   <= cfg_data;
                CFG_DIP_MARGIN:   dip_margin_reg   <= cfg_data;
                CFG_REARM_MARGIN: rearm_margin_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // average update: acc + round((s_fix - acc) * w / 2^16)
    always_comb
    begin
        s_fix    = {sample, {FRAC_BITS{1'b0}}};
        acc_base = unseeded_reg ? s_fix : acc_reg;
        diff     = $signed({1'b0, s_fix}) - $signed({1'b0, acc_base});
        weight_s = $signed({1'b0, ema_weight_reg});
        prod     = diff * weight_s;
        prod_rnd = prod + $signed(PROD_BITS'(32'sd32768));
        step     = prod_rnd >>> FRAC_BITS;
        acc_next = acc_base + step[ACC_BITS-1:0];
    end

    always_comb
    begin
        low_mark_next  = low_mark_reg;
        high_mark_next = high_mark_reg;
        if (window_start_reg)
        begin
            low_mark_next  = sample;
            high_mark_next = sample;
        end
        else
        begin
            if (sample < low_mark_reg)
            begin
                low_mark_next = sample;
            end
            if (sample > high_mark_reg)
            begin
                high_mark_next = sample;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg          <= '0;
            unseeded_reg     <= 1'b1;
            window_start_reg <= 1'b1;
            low_mark_reg     <= '0;
            high_mark_reg    <= '0;
            p_valid_reg      <= 1'b0;
            p_last_reg       <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                acc_reg          <= acc_next;
                unseeded_reg     <= 1'b0;
                window_start_reg <= window_last;
                low_mark_reg     <= low_mark_next;
                high_mark_reg    <= high_mark_next;
                p_valid_reg      <= 1'b1;
                p_last_reg       <= window_last;
            end
            else if (p_fire)
            begin
                p_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            p_sample_reg <= sample;
            p_acc_reg    <= acc_next;
            p_min_reg    <= low_mark_next;
            p_max_reg    <= high_mark_next;
        end
    end

    // dip and re-arm checks against the updated average
    always_comb
    begin
        p_sfix    = {p_sample_reg, {FRAC_BITS{1'b0}}};
        dip_lhs   = {1'b0, p_sfix} + (ACC_BITS+1)'({dip_margin_reg, {OUT_SHIFT{1'b0}}});
        rearm_rhs = {1'b0, p_acc_reg} + (ACC_BITS+1)'({rearm_margin_reg, {OUT_SHIFT{1'b0}}});
        dip_hit   = armed_reg && (dip_lhs < {1'b0, p_acc_reg});
        rearm_hit = {1'b0, p_sfix} > rearm_rhs;
        dips_next = dips_reg;
        armed_next = armed_reg;
        if (dip_hit)
        begin
            armed_next = 1'b0;
            if (dips_reg != COUNT_MAX)
            begin
                dips_next = dips_reg + 1'b1;
            end
        end
        if (rearm_hit)
        begin
            armed_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg     <= 1'b1;
            dips_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (p_fire)
            begin
                if (p_last_reg)
                begin
                    armed_reg <= 1'b1;
                    dips_reg  <= '0;
                end
                else
                begin
                    armed_reg <= armed_next;
                    dips_reg  <= dips_next;
                end
            end
            if (p_fire && p_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_fire && p_last_reg)
        begin
            out_min_reg  <= p_min_reg;
            out_max_reg  <= p_max_reg;
            out_avg_reg  <= p_acc_reg[OUT_SHIFT +: AVG_BITS];
            out_dips_reg <= dips_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign window_min    = out_min_reg;
    assign window_max    = out_max_reg;
    assign average_level = out_avg_reg;
    assign dip_count     = out_dips_reg;

    `ASSERT_CLK(a_min_le_max, out_valid_reg |-> (out_min_reg <= out_max_reg), "window min above max")
    `ASSERT_CLK(a_last_reaches_stage, in_fire && window_last |=> p_valid_reg && p_last_reg, "last item lost")
    `ASSERT_CLK(a_seed_once, !unseeded_reg |=> !unseeded_reg, "average seeded twice")
    `ASSERT_ALWAYS(a_no_result_in_reset, !rst_n |=> !out_valid_reg, "result during reset")

endmodule

`default_nettype wire
